// ===== src/mpt_pkg.sv =====
// shared constants, types and saturation helpers for the tile update block
package mpt_pkg;

    localparam int TILE         = 64;
    localparam int SERIES_DEPTH = 256;
    localparam int TILE_AW      = $clog2(TILE);
    localparam int SER_AW       = $clog2(SERIES_DEPTH);
    localparam int CNT_W        = $clog2(TILE + 1);
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = 97;

    localparam logic [2:0] CMD_LOAD_SERIES  = 3'd0;
    localparam logic [2:0] CMD_LOAD_COV     = 3'd1;
    localparam logic [2:0] CMD_LOAD_PROFILE = 3'd2;
    localparam logic [2:0] CMD_RUN          = 3'd3;
    localparam logic [2:0] CMD_READ         = 3'd4;

    localparam logic [2:0] CFG_TILE_LENGTH = 3'd0;
    localparam logic [2:0] CFG_ROW_OFFSET  = 3'd1;
    localparam logic [2:0] CFG_COL_OFFSET  = 3'd2;
    localparam logic [2:0] CFG_EDGE_MODE   = 3'd3;
    localparam logic [2:0] CFG_EDGE_BOUND  = 3'd4;

    typedef struct packed {
        logic start;
        logic advance;
        logic clear;
    } walk_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] r;
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] len;
        logic             last;
        logic             empty;
    } walk_stat_t;

    typedef struct packed {
        logic valid;
        logic clear;
        logic high;
    } mac_ctrl_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sat_add64 = s[63:0];
    endfunction

    // floor(acc / 2^24) clamped to 64 bits
    function automatic logic signed [63:0] sat_scale64(input logic signed [ACC_W-1:0] acc);
        if (acc[96:87] == {10{acc[96]}})
            sat_scale64 = acc[87:24];
        else
            sat_scale64 = acc[96] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    // floor(acc / 2^26) clamped to 32 bits
    function automatic logic signed [31:0] sat_corr32(input logic signed [ACC_W-1:0] acc);
        if (acc[96:57] == {40{acc[96]}})
            sat_corr32 = acc[57:26];
        else
            sat_corr32 = acc[96] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

endpackage

// ===== src/mpt_walk.sv =====
// row and diagonal counters that walk one tile in square or edge order
module mpt_walk
    import mpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  walk_ctrl_t ctrl,
    input  logic [6:0] tile_length,
    input  logic       edge_mode,
    input  logic [7:0] edge_bound,
    output walk_stat_t stat
);

    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] len;
    logic [15:0]      dl, rl, r1, d1;
    logic             last;

    always_comb
    begin
        len = (32'(tile_length) > TILE) ? CNT_W'(TILE) : CNT_W'(tile_length);
        dl  = (16'(edge_bound) < 16'(len)) ? 16'(edge_bound) : 16'(len);
        rl  = 16'(edge_bound) - 16'(d_reg);
        if (rl > 16'(len))
            rl = 16'(len);
        r1 = 16'(r_reg) + 16'd1;
        d1 = 16'(d_reg) + 16'd1;
        if (edge_mode)
            last = (r1 >= rl) && (d1 >= dl);
        else
            last = (r1 >= 16'(len)) && (d1 >= 16'(len));

        r_next = r_reg;
        d_next = d_reg;
        if (ctrl.start || ctrl.clear)
        begin
            r_next = '0;
            d_next = '0;
        end
        else if (ctrl.advance)
        begin
            if (edge_mode)
            begin
                // edge tile runs down each diagonal
                if (r1 >= rl)
                begin
                    r_next = '0;
                    d_next = d_reg + 1'b1;
                end
                else
                    r_next = r_reg + 1'b1;
            end
            else
            begin
                if (d1 >= 16'(len))
                begin
                    d_next = '0;
                    r_next = r_reg + 1'b1;
                end
                else
                    d_next = d_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
            d_reg <= d_next;
        end
    end

    assign stat.r     = r_reg;
    assign stat.d     = d_reg;
    assign stat.len   = len;
    assign stat.last  = last;
    assign stat.empty = (len == '0) || (edge_mode && (edge_bound == 8'd0));

endmodule

// ===== src/mpt_mac.sv =====
// shared 33x33 signed multiplier with a registered product and a wide accumulator
module mpt_mac
    import mpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [ACC_W-1:0]  acc
);

    mac_ctrl_t                ctrl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
            prod_reg <= op_a * op_b;
    end

    always_comb
    begin
        // upper partial product lands 32 bits up
        if (ctrl_reg.high)
            addend = {prod_reg[64:0], 32'd0};
        else
            addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_next = (ctrl_reg.clear ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_reg.valid)
            acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== src/matrix_profile_tile_update_core.sv =====
// top level: command decode, stores, visit sequencer and result register
// Loads are taken one word per cycle while the block is idle. A read fetches the store
// entries, then waits for a free output register. A run walks the tile one visit at a
// time; every visit passes through one shared 33x33 multiplier (two cross products, then
// the two halves of each scaling step) and one profile port that updates the row entry
// and then the column entry. The block is stalled for the whole run. The result word sits
// in an output register, so the next command is taken while it waits.
module matrix_profile_tile_update_core
    import mpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic [7:0]         index,
    input  logic signed [31:0] first_diff,
    input  logic signed [31:0] second_diff,
    input  logic signed [31:0] inv_norm,
    input  logic signed [63:0] cov_in,
    input  logic signed [31:0] corr_in,
    input  logic [16:0]        match_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               done_res,
    output logic [7:0]         index_out,
    output logic signed [63:0] cov_out,
    output logic signed [31:0] corr_out,
    output logic [16:0]        match_out
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_RD_OUT = 19'h00002,
        S_V_RD   = 19'h00004,
        S_V_X1   = 19'h00008,
        S_V_X2   = 19'h00010,
        S_V_X3   = 19'h00020,
        S_T0     = 19'h00040,
        S_T1     = 19'h00080,
        S_T2     = 19'h00100,
        S_T3     = 19'h00200,
        S_C0     = 19'h00400,
        S_C1     = 19'h00800,
        S_C2     = 19'h01000,
        S_C3     = 19'h02000,
        S_P0     = 19'h04000,
        S_P1     = 19'h08000,
        S_P2     = 19'h10000,
        S_P3     = 19'h20000,
        S_FIN    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  tile_length_reg;
    logic [15:0] row_offset_reg;
    logic [7:0]  col_offset_reg;
    logic        edge_mode_reg;
    logic [7:0]  edge_bound_reg;

    walk_ctrl_t walk_ctrl;
    walk_stat_t walk;
    mac_ctrl_t  mac_ctrl;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic        in_take, out_free, out_load, accumulate;
    logic [SER_AW-1:0] pr, pc;
    logic [16:0] match_pr, match_pc;

    // series stores
    logic signed [31:0] fd_mem [SERIES_DEPTH];
    logic signed [31:0] sd_mem [SERIES_DEPTH];
    logic signed [31:0] in_mem [SERIES_DEPTH];
    logic signed [31:0] fd_a_q, fd_b_q, sd_a_q, sd_b_q, in_a_q, in_b_q;
    logic               ser_we, ser_re;

    // covariance store
    logic signed [63:0] cov_mem [TILE];
    logic signed [63:0] cov_q, cov_wdata;
    logic [TILE_AW-1:0] cov_waddr, cov_raddr;
    logic               cov_we, cov_re;

    // profile stores
    logic signed [31:0] corr_mem  [SERIES_DEPTH];
    logic [16:0]        match_mem [SERIES_DEPTH];
    logic signed [31:0] corr_q, corr_wdata;
    logic [16:0]        match_q, match_wdata;
    logic [SER_AW-1:0]  prof_waddr, prof_raddr;
    logic               prof_we, prof_re;

    logic signed [63:0] cov_reg, cov_next;
    logic signed [63:0] t_reg;
    logic signed [31:0] c_reg;
    logic [7:0]         ix_reg;
    logic               ix_tile_reg, ix_ser_reg;

    logic               out_valid_reg;
    logic               done_reg;
    logic [7:0]         index_out_reg;
    logic signed [63:0] cov_out_reg;
    logic signed [31:0] corr_out_reg;
    logic [16:0]        match_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_length_reg <= 7'd64;
            row_offset_reg  <= '0;
            col_offset_reg  <= '0;
            edge_mode_reg   <= 1'b0;
            edge_bound_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TILE_LENGTH: tile_length_reg <= cfg_data[6:0];
                CFG_ROW_OFFSET:  row_offset_reg  <= cfg_data;
                CFG_COL_OFFSET:  col_offset_reg  <= cfg_data[7:0];
                CFG_EDGE_MODE:   edge_mode_reg   <= cfg_data[0];
                CFG_EDGE_BOUND:  edge_bound_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    mpt_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (walk_ctrl),
        .tile_length (tile_length_reg),
        .edge_mode   (edge_mode_reg),
        .edge_bound  (edge_bound_reg),
        .stat        (walk)
    );

    mpt_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod),
        .acc   (acc)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign accumulate = (walk.r != '0);

    assign pr       = SER_AW'(32'(walk.r));
    assign pc       = SER_AW'(32'(walk.r) + 32'(walk.d) + 32'(col_offset_reg));
    assign match_pr = 17'(32'(walk.r) + 32'(walk.d) + 32'(col_offset_reg)
                          + 32'(row_offset_reg));
    assign match_pc = 17'(32'(walk.r) + 32'(row_offset_reg));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        walk_ctrl  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (cmd)
                        CMD_RUN:
                        begin
                            walk_ctrl.start = 1'b1;
                            state_next = walk.empty ? S_FIN : S_V_RD;
                        end
                        CMD_READ: state_next = S_RD_OUT;
                        default: ;
                    endcase
                end
            end
            S_RD_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_V_RD: state_next = S_V_X1;
            S_V_X1: state_next = S_V_X2;
            S_V_X2: state_next = S_V_X3;
            S_V_X3: state_next = S_T0;
            S_T0:   state_next = S_T1;
            S_T1:   state_next = S_T2;
            S_T2:   state_next = S_T3;
            S_T3:   state_next = S_C0;
            S_C0:   state_next = S_C1;
            S_C1:   state_next = S_C2;
            S_C2:   state_next = S_C3;
            S_C3:   state_next = S_P0;
            S_P0:   state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:
            begin
                if (walk.last)
                    state_next = S_FIN;
                else
                begin
                    walk_ctrl.advance = 1'b1;
                    state_next = S_V_RD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    walk_ctrl.clear = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // multiplier operand select
    always_comb
    begin
        mac_ctrl = '0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            S_V_X1:
            begin
                mac_ctrl.valid = 1'b1;
                mul_a = {fd_a_q[31], fd_a_q};
                mul_b = {sd_b_q[31], sd_b_q};
            end
            S_V_X2:
            begin
                mac_ctrl.valid = 1'b1;
                mul_a = {fd_b_q[31], fd_b_q};
                mul_b = {sd_a_q[31], sd_a_q};
            end
            S_T0:
            begin
                mac_ctrl = '{valid: 1'b1, clear: 1'b1, high: 1'b0};
                mul_a = {1'b0, cov_reg[31:0]};
                mul_b = {in_a_q[31], in_a_q};
            end
            S_T1:
            begin
                mac_ctrl = '{valid: 1'b1, clear: 1'b0, high: 1'b1};
                mul_a = {cov_reg[63], cov_reg[63:32]};
                mul_b = {in_a_q[31], in_a_q};
            end
            S_C0:
            begin
                mac_ctrl = '{valid: 1'b1, clear: 1'b1, high: 1'b0};
                mul_a = {1'b0, t_reg[31:0]};
                mul_b = {in_b_q[31], in_b_q};
            end
            S_C1:
            begin
                mac_ctrl = '{valid: 1'b1, clear: 1'b0, high: 1'b1};
                mul_a = {t_reg[63], t_reg[63:32]};
                mul_b = {in_b_q[31], in_b_q};
            end
            default: ;
        endcase
    end

    // covariance update, two saturating adds of the cross products on every row but the first
    always_comb
    begin
        cov_next = cov_reg;
        if (state_reg == S_V_X1)
            cov_next = cov_q;
        else if (((state_reg == S_V_X2) || (state_reg == S_V_X3)) && accumulate)
            cov_next = sat_add64(cov_reg, prod[63:0]);
    end

    always_ff @(posedge clk)
    begin
        cov_reg <= cov_next;
        if (state_reg == S_T3)
            t_reg <= sat_scale64(acc);
        if (state_reg == S_C3)
            c_reg <= sat_corr32(acc);
        if (in_take && (cmd == CMD_READ))
        begin
            ix_reg      <= index;
            ix_tile_reg <= (32'(index) < TILE);
            ix_ser_reg  <= (32'(index) < SERIES_DEPTH);
        end
    end

    // series stores
    assign ser_we = in_take && (cmd == CMD_LOAD_SERIES) && (32'(index) < SERIES_DEPTH);
    assign ser_re = (state_reg == S_V_RD);

    always_ff @(posedge clk)
    begin
        if (ser_we)
        begin
            fd_mem[SER_AW'(index)] <= first_diff;
            sd_mem[SER_AW'(index)] <= second_diff;
            in_mem[SER_AW'(index)] <= inv_norm;
        end
        if (ser_re)
        begin
            fd_a_q <= fd_mem[pr];
            fd_b_q <= fd_mem[pc];
            sd_a_q <= sd_mem[pr];
            sd_b_q <= sd_mem[pc];
            in_a_q <= in_mem[pr];
            in_b_q <= in_mem[pc];
        end
    end

    // covariance store
    always_comb
    begin
        cov_we    = 1'b0;
        cov_waddr = TILE_AW'(index);
        cov_wdata = cov_in;
        if (state_reg == S_V_X3)
        begin
            cov_we    = accumulate;
            cov_waddr = TILE_AW'(walk.d);
            cov_wdata = cov_next;
        end
        else if (in_take && (cmd == CMD_LOAD_COV) && (32'(index) < TILE))
            cov_we = 1'b1;
        cov_re    = (state_reg == S_V_RD) || (in_take && (cmd == CMD_READ));
        cov_raddr = (state_reg == S_V_RD) ? TILE_AW'(walk.d) : TILE_AW'(index);
    end

    always_ff @(posedge clk)
    begin
        if (cov_we)
            cov_mem[cov_waddr] <= cov_wdata;
        if (cov_re)
            cov_q <= cov_mem[cov_raddr];
    end

    // profile store, row entry first then column entry
    always_comb
    begin
        prof_we     = 1'b0;
        prof_waddr  = SER_AW'(index);
        corr_wdata  = corr_in;
        match_wdata = match_in;
        prof_re     = 1'b0;
        prof_raddr  = SER_AW'(index);
        unique case (state_reg)
            S_IDLE:
            begin
                prof_we = in_take && (cmd == CMD_LOAD_PROFILE)
                          && (32'(index) < SERIES_DEPTH);
                prof_re = in_take && (cmd == CMD_READ);
            end
            S_P0:
            begin
                prof_re    = 1'b1;
                prof_raddr = pr;
            end
            S_P1:
            begin
                prof_we     = (c_reg > corr_q);
                prof_waddr  = pr;
                corr_wdata  = c_reg;
                match_wdata = match_pr;
            end
            S_P2:
            begin
                prof_re    = 1'b1;
                prof_raddr = pc;
            end
            S_P3:
            begin
                prof_we     = (c_reg > corr_q);
                prof_waddr  = pc;
                corr_wdata  = c_reg;
                match_wdata = match_pc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prof_we)
        begin
            corr_mem[prof_waddr]  <= corr_wdata;
            match_mem[prof_waddr] <= match_wdata;
        end
        if (prof_re)
        begin
            corr_q  <= corr_mem[prof_raddr];
            match_q <= match_mem[prof_raddr];
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (state_reg == S_FIN)
            begin
                done_reg      <= 1'b1;
                index_out_reg <= '0;
                cov_out_reg   <= '0;
                corr_out_reg  <= '0;
                match_out_reg <= '0;
            end
            else
            begin
                done_reg      <= 1'b0;
                index_out_reg <= ix_reg;
                cov_out_reg   <= ix_tile_reg ? cov_q : '0;
                corr_out_reg  <= ix_ser_reg ? corr_q : '0;
                match_out_reg <= ix_ser_reg ? match_q : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = done_reg;
    assign index_out = index_out_reg;
    assign cov_out   = cov_out_reg;
    assign corr_out  = corr_out_reg;
    assign match_out = match_out_reg;

`ifndef SYNTHESIS
    a_walk_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_load) |=> (walk.r == '0 && walk.d == '0))
        else $error("walk counters not cleared after run");

    a_walk_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_V_RD || state_reg == S_P3) |-> (walk.r < walk.len && walk.d < walk.len))
        else $error("visit outside tile");

    a_cov_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_V_X3 && cov_we) |-> (walk.r != '0))
        else $error("covariance updated on first row");
`endif

endmodule

// ===== test/tb_matrix_profile_tile_update_checker.sv =====
`timescale 1ns / 1ps
// checker for the tile update block: tracks loads and runs, predicts result words, compares
module tb_matrix_profile_tile_update_checker
    import mpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic [7:0]         index,
    input  logic signed [31:0] first_diff,
    input  logic signed [31:0] second_diff,
    input  logic signed [31:0] inv_norm,
    input  logic signed [63:0] cov_in,
    input  logic signed [31:0] corr_in,
    input  logic [16:0]        match_in,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               done_res,
    input  logic [7:0]         index_out,
    input  logic signed [63:0] cov_out,
    input  logic signed [31:0] corr_out,
    input  logic [16:0]        match_out,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic               done;
        logic [7:0]         idx;
        logic signed [63:0] cov;
        logic signed [31:0] corr;
        logic [16:0]        match;
    } tile_word_t;

    logic signed [31:0] fd_mem   [SERIES_DEPTH];
    logic signed [31:0] sd_mem   [SERIES_DEPTH];
    logic signed [31:0] norm_mem [SERIES_DEPTH];
    logic signed [63:0] cov_mem  [TILE];
    logic signed [31:0] corr_mem [SERIES_DEPTH];
    logic [16:0]        match_mem[SERIES_DEPTH];

    logic [6:0]  tile_len_q;
    logic [15:0] row_off_q;
    logic [7:0]  col_off_q;
    logic        edge_q;
    logic [7:0]  bound_q;

    tile_word_t expected_words[$];

    assign pending = expected_words.size();

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // floor(a*b / 2^sh), clamped to 64 bits or, when narrow, to 32 bits
    function automatic logic signed [63:0] mul_floor_sat(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh, input bit narrow);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        q = p >>> sh;
        if (narrow)
        begin
            if (q[127:31] != {97{q[127]}})
                return q[127] ? -64'sd2147483648 : 64'sd2147483647;
        end
        else if (q[127:63] != {65{q[127]}})
            return q[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return q[63:0];
    endfunction

    task automatic visit_cell(input int r, input int d, input bit accumulate);
        int                 pr;
        int                 pc;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] t;
        logic signed [63:0] c;
        pr = r % SERIES_DEPTH;
        pc = (r + d + col_off_q) % SERIES_DEPTH;
        if (accumulate)
        begin
            x = fd_mem[pr];
            y = sd_mem[pc];
            cov_mem[d] = add_sat(cov_mem[d], x * y);
            x = fd_mem[pc];
            y = sd_mem[pr];
            cov_mem[d] = add_sat(cov_mem[d], x * y);
        end
        x = norm_mem[pr];
        t = mul_floor_sat(cov_mem[d], x, 24, 1'b0);
        y = norm_mem[pc];
        c = mul_floor_sat(t, y, 26, 1'b1);
        x = corr_mem[pr];
        if (c > x)
        begin
            corr_mem[pr]  = c[31:0];
            match_mem[pr] = 17'(r + d + col_off_q + row_off_q);
        end
        x = corr_mem[pc];
        if (c > x)
        begin
            corr_mem[pc]  = c[31:0];
            match_mem[pc] = 17'(r + row_off_q);
        end
    endtask

    task automatic walk_tile();
        int len;
        int dl;
        int rl;
        len = (tile_len_q > TILE) ? TILE : tile_len_q;
        if (!edge_q)
        begin
            for (int d = 0; d < len; d++)
                visit_cell(0, d, 1'b0);
            for (int r = 1; r < len; r++)
                for (int d = 0; d < len; d++)
                    visit_cell(r, d, 1'b1);
        end
        else
        begin
            dl = (len < bound_q) ? len : bound_q;
            for (int d = 0; d < dl; d++)
            begin
                rl = bound_q - d;
                if (rl > len)
                    rl = len;
                visit_cell(0, d, 1'b0);
                for (int r = 1; r < rl; r++)
                    visit_cell(r, d, 1'b1);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tile_word_t w;
        tile_word_t got;
        if (!rst_n)
        begin
            tile_len_q = 7'd64;
            row_off_q  = '0;
            col_off_q  = '0;
            edge_q     = 1'b0;
            bound_q    = '0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TILE_LENGTH: tile_len_q = cfg_data[6:0];
                    CFG_ROW_OFFSET:  row_off_q  = cfg_data;
                    CFG_COL_OFFSET:  col_off_q  = cfg_data[7:0];
                    CFG_EDGE_MODE:   edge_q     = cfg_data[0];
                    CFG_EDGE_BOUND:  bound_q    = cfg_data[7:0];
                    default: ;
                endcase
            end
            // result word sampled before the new input is applied
            if (out_valid && !out_stall)
            begin
                got = '{done_res, index_out, cov_out, corr_out, match_out};
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected word: %p", got);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (got !== w)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", w, got);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (cmd)
                    CMD_LOAD_SERIES:
                    begin
                        fd_mem[index]   = first_diff;
                        sd_mem[index]   = second_diff;
                        norm_mem[index] = inv_norm;
                    end
                    CMD_LOAD_COV:
                        if (index < TILE)
                            cov_mem[index] = cov_in;
                    CMD_LOAD_PROFILE:
                    begin
                        corr_mem[index]  = corr_in;
                        match_mem[index] = match_in;
                    end
                    CMD_RUN:
                    begin
                        walk_tile();
                        expected_words.push_back('{1'b1, 8'd0, 64'sd0, 32'sd0, 17'd0});
                    end
                    CMD_READ:
                    begin
                        w.done  = 1'b0;
                        w.idx   = index;
                        w.cov   = (index < TILE) ? cov_mem[index] : 64'sd0;
                        w.corr  = corr_mem[index];
                        w.match = match_mem[index];
                        expected_words.push_back(w);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb_matrix_profile_tile_update_core.sv =====
`timescale 1ns / 1ps
// top of the tile update testbench: clock, reset, stimulus and verdict
module tb_matrix_profile_tile_update_core;
    import mpt_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         cmd;
    logic [7:0]         index;
    logic signed [31:0] first_diff;
    logic signed [31:0] second_diff;
    logic signed [31:0] inv_norm;
    logic signed [63:0] cov_in;
    logic signed [31:0] corr_in;
    logic [16:0]        match_in;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               done_res;
    logic [7:0]         index_out;
    logic signed [63:0] cov_out;
    logic signed [31:0] corr_out;
    logic [16:0]        match_out;
    int                 fail_count;
    int                 pending;
    bit                 quiet;
    int                 out_hold = 0;

    always #5 clk = ~clk;

    matrix_profile_tile_update_core u_top (.*);

    tb_matrix_profile_tile_update_checker u_checker (.*);

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold  <= out_hold - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_hold  <= $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [31:0] diff_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0000_1000)) - 32'sh0000_0800);
        endcase
    endfunction

    function automatic logic [31:0] norm_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0200_0000);
    endfunction

    task automatic send_word(input logic [2:0] c, input logic [7:0] ix,
                             input logic [31:0] fd, input logic [31:0] sd,
                             input logic [31:0] nrm, input logic [63:0] cv,
                             input logic [31:0] cr, input logic [16:0] mt);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        index       <= ix;
        first_diff  <= fd;
        second_diff <= sd;
        inv_norm    <= nrm;
        cov_in      <= cv;
        corr_in     <= cr;
        match_in    <= mt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input logic [2:0] c, input logic [7:0] ix);
        send_word(c, ix, diff_value(), diff_value(), norm_value(),
                  {$urandom, $urandom} >>> $urandom_range(0, 40),
                  $urandom_range(0, 1) ? $urandom : 32'h8000_0000 + $urandom_range(0, 99),
                  $urandom_range(0, 17'h1FFFF));
    endtask

    task automatic write_reg(input logic [2:0] ri, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input int len, input int roff, input int coff,
                             input int em, input int bnd);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(CFG_TILE_LENGTH, 16'(len));
        write_reg(CFG_ROW_OFFSET, 16'(roff));
        write_reg(CFG_COL_OFFSET, 16'(coff));
        write_reg(CFG_EDGE_MODE, 16'(em));
        write_reg(CFG_EDGE_BOUND, 16'(bnd));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [2:0] c;
        quiet       = 1'b0;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        cmd         <= '0;
        index       <= '0;
        first_diff  <= '0;
        second_diff <= '0;
        inv_norm    <= '0;
        cov_in      <= '0;
        corr_in     <= '0;
        match_in    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store so nothing unwritten is ever read
        for (int i = 0; i < SERIES_DEPTH; i++)
            send_random(CMD_LOAD_SERIES, 8'(i));
        for (int i = 0; i < TILE; i++)
            send_random(CMD_LOAD_COV, 8'(i));
        for (int i = 0; i < SERIES_DEPTH; i++)
            send_random(CMD_LOAD_PROFILE, 8'(i));

        // directed: extremes, reads past the covariance depth, unused commands
        send_word(CMD_LOAD_SERIES, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  '0, '0, '0);
        send_word(CMD_LOAD_SERIES, 8'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  '0, '0, '0);
        send_word(CMD_LOAD_COV, 8'd63, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
        send_word(CMD_LOAD_COV, 8'd0, '0, '0, '0, 64'h8000_0000_0000_0000, '0, '0);
        send_word(CMD_LOAD_COV, 8'd200, '0, '0, '0, 64'h1234, '0, '0);
        send_word(CMD_LOAD_PROFILE, 8'd255, '0, '0, '0, '0, 32'h8000_0000, 17'h1FFFF);
        send_word(CMD_LOAD_PROFILE, 8'd3, '0, '0, '0, '0, 32'h7FFF_FFFF, 17'h0);
        send_random(CMD_READ, 8'd0);
        send_random(CMD_READ, 8'd63);
        send_random(CMD_READ, 8'd64);
        send_random(CMD_READ, 8'd255);
        for (int k = CMD_READ + 1; k < 8; k++)
            send_random(3'(k), 8'($urandom));
        send_random(CMD_RUN, 8'd0);

        // zero length tile, then an oversize one that saturates to the full tile
        configure(0, 0, 0, 0, 0);
        send_random(CMD_RUN, 8'd0);
        configure(127, 65535, 128, 0, 128);
        send_random(CMD_RUN, 8'd0);
        send_random(CMD_READ, 8'd1);
        configure(64, 0, 0, 1, 128);
        send_random(CMD_RUN, 8'd0);
        configure(5, 65535, 128, 1, 0);
        send_random(CMD_RUN, 8'd0);
        send_random(CMD_READ, 8'd128);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(1, 0, 0, 0, 0);
                1: configure(8, 65535, 128, 1, 128);
                2: configure(6, 0, 128, 1, 3);
                default: configure($urandom_range(1, 10), $urandom_range(0, 65535),
                                   $urandom_range(0, 128), $urandom_range(0, 1),
                                   $urandom_range(0, 128));
            endcase
            quiet = (ph == 7);
            for (int n = 0; n < 140; n++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5:  c = CMD_LOAD_SERIES;
                    6, 7, 8:           c = CMD_LOAD_COV;
                    9, 10, 11:         c = CMD_LOAD_PROFILE;
                    12:                c = CMD_RUN;
                    13, 14, 15, 16, 17: c = CMD_READ;
                    default:           c = 3'($urandom_range(0, 7));
                endcase
                send_random(c, 8'($urandom_range(0, 255)));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mpt_pkg.sv
src/mpt_walk.sv
src/mpt_mac.sv
src/matrix_profile_tile_update_core.sv
test/tb_matrix_profile_tile_update_checker.sv
test/tb_matrix_profile_tile_update_core.sv
